>>> design/sha_pkg.sv
// ============================================================================
// sha_pkg: shared constants and round functions for the SHA-256 engine
// Holds the initial hash value, round constants and the mixing functions.
// ============================================================================
package sha_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned HASH_WORDS  = 8;

    typedef logic [31:0] word_t;
    typedef logic [5:0]  byte_idx_t;
    typedef logic [60:0] msg_len_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

>>> design/sha_if.sv
// ============================================================================
// sha_in_if / sha_out_if: valid-ready channels of the SHA-256 engine
// Request channel carries message bytes, response channel digest words.
// ============================================================================
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        word_is_last;
    modport source (output valid, digest_word, word_is_last, input ready);
    modport sink   (input valid, digest_word, word_is_last, output ready);
endinterface

>>> design/sha_round.sv
// ============================================================================
// sha_round: one SHA-256 compression round
// Combinational round step on the working variables a..h.
// ============================================================================
module sha_round
    import sha_pkg::*;
(
    input  word_t a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in,
    input  word_t k_in,
    input  word_t w_in,
    output word_t a_out, e_out
);
    word_t t1;
    word_t t2;

    always_comb
    begin
        t1 = h_in + big_sigma1(e_in) + ((e_in & f_in) ^ (~e_in & g_in)) + k_in + w_in;
        t2 = big_sigma0(a_in) + ((a_in & b_in) ^ (a_in & c_in) ^ (b_in & c_in));
        a_out = t1 + t2;
        e_out = d_in + t1;
    end
endmodule

>>> design/sha256_hash_engine_core.sv
// ============================================================================
// sha256_hash_engine_core: byte-fed SHA-256 engine
// Absorbs at most one message byte per request, compresses each 64-byte block and
// emits the eight digest words after the last request.
// ============================================================================
//
//  channel | dir | payload                      | notes
//  --------+-----+------------------------------+-------------------------
//  req     | in  | data_byte, has_byte, last    | at most one message byte a request
//  rsp     | out | digest_word, word_is_last    | 8 words per finished message
//
// A byte that fills the block starts the reads of the block memory into the
// schedule window (16 schedule words through a registered read port), then 64
// rounds and one fold step. Each padding block first writes every byte from
// the fill point to the end of the block (all 64 on a fresh block), then goes
// through the same load, rounds and fold; these steps run one after another on
// the single round unit and the one-read-port block memory.
// The final message then emits its eight digest words, each held until taken.
// Reset is asynchronous and restores the initial hash value and empty message;
// the block memory is not cleared, since padding rewrites every unread byte.
// A stalled rsp channel holds the engine; no new request is taken meanwhile.
// ============================================================================
module sha256_hash_engine_core
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink    req,
    sha_out_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,   // take bytes
        S_PAD,    // write padding bytes into memory
        S_LOAD,   // read 16 schedule words
        S_ROUND,  // 64 rounds
        S_FOLD,   // add into chaining words
        S_OUT     // emit digest words
    } state_t;

    state_t    state_reg;
    byte_idx_t fill_reg;
    msg_len_t  len_reg;
    logic      final_reg;   // finishing message
    logic      len_blk_reg; // padding block holds length
    logic      more_reg;    // another padding block follows
    logic      mark_reg;    // this padding pass writes the 0x80 byte
    logic [6:0] cnt_reg;
    word_t     h_reg [HASH_WORDS];
    word_t     v_reg [HASH_WORDS];
    word_t     w_reg [16];
    logic [2:0] oidx_reg;

    // block memory, 16 words of 32 bits, byte writable
    logic [7:0] mem0 [16];
    logic [7:0] mem1 [16];
    logic [7:0] mem2 [16];
    logic [7:0] mem3 [16];
    word_t      rd_reg;

    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic [3:0] rd_addr;

    word_t a_nx;
    word_t e_nx;
    word_t w_new;
    word_t w_cur;
    logic [63:0] bits;

    assign bits = {len_reg, 3'b000};
    assign w_cur = w_reg[0];
    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];

    sha_round u_round (
        .a_in(v_reg[0]), .b_in(v_reg[1]), .c_in(v_reg[2]), .d_in(v_reg[3]),
        .e_in(v_reg[4]), .f_in(v_reg[5]), .g_in(v_reg[6]), .h_in(v_reg[7]),
        .k_in(round_k(cnt_reg[5:0])), .w_in(w_cur),
        .a_out(a_nx), .e_out(e_nx)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.digest_word = h_reg[oidx_reg];
    assign rsp.word_is_last = (oidx_reg == 3'd7);

    // memory port control
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = fill_reg;
        wr_data = req.data_byte;
        rd_addr = cnt_reg[3:0];
        case (state_reg)
            S_IDLE:
            begin
                wr_en = req.valid && req.has_byte;
            end
            S_PAD:
            begin
                wr_en = 1'b1;
                wr_addr = cnt_reg[5:0];
                if (cnt_reg[5:0] == fill_reg && mark_reg)
                    wr_data = 8'h80;
                else if (cnt_reg[5:0] >= 6'd56 && len_blk_reg)
                    wr_data = bits[8'(63 - (cnt_reg[2:0] * 8)) -: 8];
                else
                    wr_data = 8'h00;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_addr[1:0])
                2'd0: mem0[wr_addr[5:2]] <= wr_data;
                2'd1: mem1[wr_addr[5:2]] <= wr_data;
                2'd2: mem2[wr_addr[5:2]] <= wr_data;
                default: mem3[wr_addr[5:2]] <= wr_data;
            endcase
        end
        rd_reg <= {mem0[rd_addr], mem1[rd_addr], mem2[rd_addr], mem3[rd_addr]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            len_reg <= '0;
            final_reg <= 1'b0;
            len_blk_reg <= 1'b0;
            more_reg <= 1'b0;
            mark_reg <= 1'b0;
            cnt_reg <= '0;
            oidx_reg <= '0;
            for (int i = 0; i < HASH_WORDS; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        byte_idx_t f;
                        f = fill_reg;
                        if (req.has_byte)
                        begin
                            f = fill_reg + 6'd1;
                            len_reg <= len_reg + 61'd1;
                        end
                        fill_reg <= f;
                        final_reg <= req.last;
                        cnt_reg <= '0;
                        if (req.has_byte && f == 6'd0)
                            state_reg <= S_LOAD;      // full block
                        else if (req.last)
                        begin
                            // skip 0x80 slot: mark from pad state
                            len_blk_reg <= (f < 6'd56);
                            more_reg <= (f >= 6'd56);
                            mark_reg <= 1'b1;
                            cnt_reg <= {1'b0, f};
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // pad from fill point, or whole block on the length block
                    if (cnt_reg[5:0] == 6'd63)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end
                S_LOAD:
                begin
                    // read data is registered: word i lands at cnt i+1
                    if (cnt_reg != 7'd0)
                        w_reg[cnt_reg[3:0] - 4'd1] <= rd_reg;
                    if (cnt_reg == 7'd16)
                    begin
                        cnt_reg <= '0;
                        for (int i = 0; i < HASH_WORDS; i++)
                            v_reg[i] <= h_reg[i];
                        state_reg <= S_ROUND;
                    end
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end
                S_ROUND:
                begin
                    v_reg[0] <= a_nx;
                    v_reg[1] <= v_reg[0];
                    v_reg[2] <= v_reg[1];
                    v_reg[3] <= v_reg[2];
                    v_reg[4] <= e_nx;
                    v_reg[5] <= v_reg[4];
                    v_reg[6] <= v_reg[5];
                    v_reg[7] <= v_reg[6];
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= w_new;
                    if (cnt_reg == 7'd63)
                        state_reg <= S_FOLD;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                S_FOLD:
                begin
                    for (int i = 0; i < HASH_WORDS; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    cnt_reg <= '0;
                    if (!final_reg)
                        state_reg <= S_IDLE;
                    else if (more_reg)
                    begin
                        // second padding block: zeros plus length
                        more_reg <= 1'b0;
                        len_blk_reg <= 1'b1;
                        mark_reg <= 1'b0;
                        fill_reg <= 6'd0;
                        state_reg <= S_PAD;
                    end
                    else if (len_blk_reg)
                    begin
                        oidx_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        // block filled by a last byte: pad a fresh block
                        len_blk_reg <= 1'b1;
                        mark_reg <= 1'b1;
                        fill_reg <= 6'd0;
                        state_reg <= S_PAD;
                        final_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (rsp.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < HASH_WORDS; i++)
                                h_reg[i] <= init_hash(3'(i));
                            fill_reg <= '0;
                            len_reg <= '0;
                            final_reg <= 1'b0;
                            len_blk_reg <= 1'b0;
                            mark_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
